// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

// ===== design/i2cms_pkg.sv =====
// types, codes and constants of the i2c master transfer sequencer
`timescale 1ns / 1ps

package i2cms_pkg;

   localparam logic [7:0] ADDR_LIMIT = 8'h7F;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BUSY    = 3'd1,
      ST_BADADDR = 3'd2,
      ST_BUSERR  = 3'd3,
      ST_NACK    = 3'd4,
      ST_TIMEOUT = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_READ = 2'd1,
      CMD_STOP = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      BUS_UNKNOWN = 2'd0,
      BUS_IDLE    = 2'd1,
      BUS_OWNER   = 2'd2,
      BUS_BUSY    = 2'd3
   } bus_state_type;

   typedef enum logic [1:0] {
      CSR_SMART_MODE     = 2'd0,
      CSR_STRETCH        = 2'd1,
      CSR_TIMEOUT_PERIOD = 2'd2
   } csr_index_type;

   localparam logic KIND_START = 1'b0;

   // int_flags bits
   localparam int FLAG_MB = 0;
   localparam int FLAG_SB = 1;
   // status_bits bits
   localparam int STS_ARB_LOST = 0;
   localparam int STS_BUS_ERR  = 1;
   localparam int STS_NACK     = 2;

   localparam logic [1:0] CLEAR_MB = 2'b01;
   localparam logic [1:0] CLEAR_SB = 2'b10;

   typedef struct packed {
      logic       kind;
      logic [1:0] bus_state;
      logic [7:0] slave_address;
      logic       read_not_write;
      logic [7:0] transfer_length;
      logic       repeated_start;
      logic [1:0] int_flags;
      logic [2:0] status_bits;
      logic [7:0] tx_byte;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      status_type  status_code;
      logic        done_res;
      command_type bus_command;
      logic        ack_action_set;
      logic        ack_action;
      logic        addr_write_valid;
      logic [7:0]  addr_byte;
      logic        data_write_valid;
      logic [7:0]  data_out;
      logic        data_read_valid;
      logic [7:0]  data_in;
      logic [1:0]  clear_flags;
   } rsp_type;

   typedef struct packed {
      logic        active;
      logic [7:0]  remaining;
      logic        keep_bus;
      logic [15:0] poll_count;
   } state_type;

   typedef struct packed {
      logic        smart_mode;
      logic        stretch_after_ack;
      logic [15:0] timeout_period;
   } cfg_type;

endpackage

// ===== design/i2cms_req_if.sv =====
// request channel: one start or poll transaction
`timescale 1ns / 1ps

interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] bus_state;
   logic [7:0] slave_address;
   logic       read_not_write;
   logic [7:0] transfer_length;
   logic       repeated_start;
   logic [1:0] int_flags;
   logic [2:0] status_bits;
   logic [7:0] tx_byte;
   logic [7:0] rx_byte;

   modport source (
      output valid, kind, bus_state, slave_address, read_not_write, transfer_length,
             repeated_start, int_flags, status_bits, tx_byte, rx_byte,
      input  ready
   );
   modport sink (
      input  valid, kind, bus_state, slave_address, read_not_write, transfer_length,
             repeated_start, int_flags, status_bits, tx_byte, rx_byte,
      output ready
   );
endinterface

// ===== design/i2cms_rsp_if.sv =====
// response channel: one result transaction per request
`timescale 1ns / 1ps

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status_code;
   logic       done_res;
   logic [1:0] bus_command;
   logic       ack_action_set;
   logic       ack_action;
   logic       addr_write_valid;
   logic [7:0] addr_byte;
   logic       data_write_valid;
   logic [7:0] data_out;
   logic       data_read_valid;
   logic [7:0] data_in;
   logic [1:0] clear_flags;

   modport source (
      output valid, status_code, done_res, bus_command, ack_action_set, ack_action,
             addr_write_valid, addr_byte, data_write_valid, data_out,
             data_read_valid, data_in, clear_flags,
      input  ready
   );
   modport sink (
      input  valid, status_code, done_res, bus_command, ack_action_set, ack_action,
             addr_write_valid, addr_byte, data_write_valid, data_out,
             data_read_valid, data_in, clear_flags,
      output ready
   );
endinterface

// ===== design/i2cms_step.sv =====
// decision logic for one transaction: result and next transfer state
`timescale 1ns / 1ps

module i2cms_step (
   input  i2cms_pkg::req_type   item,
   input  i2cms_pkg::state_type cur,
   input  i2cms_pkg::cfg_type   cfg,
   output i2cms_pkg::rsp_type   rsp,
   output i2cms_pkg::state_type nxt
);

   logic [16:0] count;
   logic [7:0]  rem_dec;

   assign count   = {1'b0, cur.poll_count} + 17'd1;
   assign rem_dec = cur.remaining - 8'd1;

   always_comb begin
      rsp = '0;
      nxt = cur;
      if (item.kind == i2cms_pkg::KIND_START) begin
         if (cur.active) begin
            rsp.status_code = i2cms_pkg::ST_BUSY;
         end else if (item.bus_state != i2cms_pkg::BUS_IDLE &&
                      item.bus_state != i2cms_pkg::BUS_OWNER) begin
            rsp.status_code = i2cms_pkg::ST_BUSY;
            rsp.done_res    = 1'b1;
         end else if (item.slave_address > i2cms_pkg::ADDR_LIMIT) begin
            rsp.status_code = i2cms_pkg::ST_BADADDR;
            rsp.done_res    = 1'b1;
         end else begin
            rsp.ack_action_set   = 1'b1;
            rsp.ack_action       = (item.transfer_length == 8'd1) && cfg.stretch_after_ack;
            rsp.addr_write_valid = 1'b1;
            rsp.addr_byte        = {item.slave_address[6:0], item.read_not_write};
            nxt.active           = 1'b1;
            nxt.remaining        = item.transfer_length;
            nxt.keep_bus         = item.repeated_start;
            nxt.poll_count       = '0;
         end
      end else if (cur.active) begin
         if (count > {1'b0, cfg.timeout_period}) begin
            nxt.poll_count  = '0;
            nxt.active      = 1'b0;
            rsp.status_code = i2cms_pkg::ST_TIMEOUT;
            rsp.done_res    = 1'b1;
         end else if (item.int_flags == 2'b00) begin
            nxt.poll_count = count[15:0];
         end else begin
            nxt.poll_count = '0;
            if (item.int_flags[i2cms_pkg::FLAG_MB]) begin
               if (item.status_bits[i2cms_pkg::STS_ARB_LOST]) begin
                  rsp.clear_flags = i2cms_pkg::CLEAR_MB;
                  rsp.status_code = item.status_bits[i2cms_pkg::STS_BUS_ERR]
                                    ? i2cms_pkg::ST_BUSERR : i2cms_pkg::ST_BADADDR;
                  rsp.done_res    = 1'b1;
                  nxt.active      = 1'b0;
               end else if (item.status_bits[i2cms_pkg::STS_NACK]) begin
                  rsp.status_code = i2cms_pkg::ST_NACK;
                  rsp.done_res    = 1'b1;
                  rsp.bus_command = i2cms_pkg::CMD_STOP;
                  nxt.active      = 1'b0;
               end else if (cur.remaining == 8'd0) begin
                  rsp.status_code = i2cms_pkg::ST_OK;
                  rsp.done_res    = 1'b1;
                  rsp.bus_command = cur.keep_bus ? i2cms_pkg::CMD_NONE : i2cms_pkg::CMD_STOP;
                  nxt.active      = 1'b0;
               end else begin
                  rsp.data_write_valid = 1'b1;
                  rsp.data_out         = item.tx_byte;
                  nxt.remaining        = rem_dec;
               end
            end else begin
               rsp.clear_flags = i2cms_pkg::CLEAR_SB;
               if (cur.remaining != 8'd0 && !item.status_bits[i2cms_pkg::STS_NACK]) begin
                  nxt.remaining = rem_dec;
                  if ((rem_dec == 8'd0 && !cfg.stretch_after_ack) ||
                      (rem_dec == 8'd1 && cfg.stretch_after_ack)) begin
                     rsp.ack_action_set = 1'b1;
                     rsp.ack_action     = 1'b1;
                  end
                  rsp.data_read_valid = 1'b1;
                  rsp.data_in         = item.rx_byte;
                  if (rem_dec == 8'd0) begin
                     rsp.status_code = i2cms_pkg::ST_OK;
                     rsp.done_res    = 1'b1;
                     rsp.bus_command = cur.keep_bus ? i2cms_pkg::CMD_NONE
                                                    : i2cms_pkg::CMD_STOP;
                     nxt.active      = 1'b0;
                  end else if (!cfg.smart_mode) begin
                     rsp.bus_command = i2cms_pkg::CMD_READ;
                  end
               end else begin
                  rsp.status_code = i2cms_pkg::ST_NACK;
                  rsp.done_res    = 1'b1;
                  rsp.bus_command = i2cms_pkg::CMD_STOP;
                  nxt.active      = 1'b0;
               end
            end
         end
      end
   end

endmodule

// ===== design/i2cms_csr.sv =====
// configuration registers written through the csr port
`timescale 1ns / 1ps

module i2cms_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               write_en,
   input  logic [1:0]         index,
   input  logic [15:0]        wdata,
   output i2cms_pkg::cfg_type cfg
);

   i2cms_pkg::cfg_type cfg_ff;
   i2cms_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            i2cms_pkg::CSR_SMART_MODE:     cfg_in.smart_mode        = wdata[0];
            i2cms_pkg::CSR_STRETCH:        cfg_in.stretch_after_ack = wdata[0];
            i2cms_pkg::CSR_TIMEOUT_PERIOD: cfg_in.timeout_period    = wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smart_mode        <= 1'b0;
         cfg_ff.stretch_after_ack <= 1'b0;
         cfg_ff.timeout_period    <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/i2c_master_transfer_sequencer.sv =====
// top level of the i2c master transfer sequencer
//
//   channel   dir   handshake        contents
//   req_chan  in    valid / ready    start or poll transaction
//   rsp_chan  out   valid / ready    one result transaction per request
//   csr_*     in    write enable     smart_mode, stretch_after_ack, timeout_period
//
// response path: the input register loads at the accept edge, then decision logic
// feeds the response register, which loads when the input stage advances
// throughput: one transaction per cycle unless rsp_chan stalls; state_ff closes the loop
// reset clears transfer state and valid flags, sets csr defaults; payload regs are not reset
// a stalled response holds the input stage, which then takes no further request
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer (
   input  logic               clock,
   input  logic               reset,
   i2cms_req_if.sink          req_chan,
   i2cms_rsp_if.source        rsp_chan,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

`include "assert_macros.svh"

   i2cms_pkg::cfg_type   cfg;

   // input stage
   logic                 req_valid_ff;
   i2cms_pkg::req_type   req_item_ff;
   i2cms_pkg::req_type   req_item_in;

   // transfer state, advanced once per processed transaction
   i2cms_pkg::state_type state_ff;
   i2cms_pkg::state_type state_in;

   // response register
   logic                 rsp_valid_ff;
   i2cms_pkg::rsp_type   rsp_data_ff;
   i2cms_pkg::rsp_type   rsp_in;

   logic                 stage_adv;
   logic                 req_take;

   i2cms_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .write_en (csr_write_en),
      .index    (csr_index),
      .wdata    (csr_wdata),
      .cfg      (cfg)
   );

   i2cms_step u_step (
      .item (req_item_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .rsp  (rsp_in),
      .nxt  (state_in)
   );

   // input stage moves on when the response register is empty or being drained
   assign stage_adv      = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || stage_adv;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      req_item_in.kind            = req_chan.kind;
      req_item_in.bus_state       = req_chan.bus_state;
      req_item_in.slave_address   = req_chan.slave_address;
      req_item_in.read_not_write  = req_chan.read_not_write;
      req_item_in.transfer_length = req_chan.transfer_length;
      req_item_in.repeated_start  = req_chan.repeated_start;
      req_item_in.int_flags       = req_chan.int_flags;
      req_item_in.status_bits     = req_chan.status_bits;
      req_item_in.tx_byte         = req_chan.tx_byte;
      req_item_in.rx_byte         = req_chan.rx_byte;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (stage_adv) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_item_in;
      end
      if (stage_adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status_code      = rsp_data_ff.status_code;
   assign rsp_chan.done_res         = rsp_data_ff.done_res;
   assign rsp_chan.bus_command      = rsp_data_ff.bus_command;
   assign rsp_chan.ack_action_set   = rsp_data_ff.ack_action_set;
   assign rsp_chan.ack_action       = rsp_data_ff.ack_action;
   assign rsp_chan.addr_write_valid = rsp_data_ff.addr_write_valid;
   assign rsp_chan.addr_byte        = rsp_data_ff.addr_byte;
   assign rsp_chan.data_write_valid = rsp_data_ff.data_write_valid;
   assign rsp_chan.data_out         = rsp_data_ff.data_out;
   assign rsp_chan.data_read_valid  = rsp_data_ff.data_read_valid;
   assign rsp_chan.data_in          = rsp_data_ff.data_in;
   assign rsp_chan.clear_flags      = rsp_data_ff.clear_flags;

   // an idle sequencer never carries a stale poll count
   `ASSERT_CLK(a_idle_count_clear, clock, reset, !state_ff.active |-> state_ff.poll_count == 16'd0, "poll count set while inactive")

   // a held input stage keeps its transaction
   `ASSERT_CLK(a_stage_hold, clock, reset, req_valid_ff && !stage_adv |=> req_valid_ff, "input stage dropped a transaction")

   // an address write always opens a transfer and never ends one
   `ASSERT_NEVER(a_addr_not_done, clock, reset, rsp_valid_ff && rsp_data_ff.addr_write_valid && (rsp_data_ff.done_res || !state_ff.active), "address write with end of transfer")

endmodule
